// ===== sv/sobm_pkg.sv =====
// ----------------------------------------------------------------------------
// sobm_pkg
// Shared constants, types and register codes for the Sobel edge magnitude
// block.
// ----------------------------------------------------------------------------
package sobm_pkg;

  // Largest supported line length, in pixels
  localparam int MaxSize  = 1024;
  localparam int MinSize  = 3;
  // Column/row counter width and size register width
  localparam int ColW     = $clog2(MaxSize);
  localparam int SizeW    = $clog2(MaxSize + 1);

  // Configuration port
  localparam int CfgW     = 11;
  localparam int CfgIdxW  = 1;
  localparam logic [CfgIdxW-1:0] RegImageWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 1'b1;

  // Datapath widths
  localparam int PixW     = 8;
  localparam int PosW     = 10;           // out_row / out_col
  localparam int GradW    = 11;           // signed gradient, |g| <= 1020
  localparam int SqW      = 20;           // g*g <= 1040400
  localparam int SumW     = SqW + 1;
  localparam int RootInW  = 16;           // sums of 2**16 and up saturate
  localparam int MagW     = 8;

  // Depth of the queue between front and back
  localparam int QDepth   = 2;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  // One work item handed from front to back
  typedef struct packed {
    logic signed [GradW-1:0] gx;
    logic signed [GradW-1:0] gy;
    logic [PosW-1:0]         orow;
    logic [PosW-1:0]         ocol;
    logic                    border;
    logic                    frame_end;
  } item_t;

endpackage

// ===== sv/sobel_edge_magnitude.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// Streaming 3x3 Sobel gradient magnitude over 8-bit grayscale raster pixels.
//
//   channel   direction  handshake         payload
//   pixel     in         push / full       pixel_i
//   result    out        empty / pop       magnitude_o, out_row_o, out_col_o,
//                                          saturated_o, frame_end_o
//   config    in         cfg_we_i          cfg_idx_i, cfg_data_i
//
// The front takes a pixel, then looks up the line stores, and takes no new
// pixel during the lookup. An interior result in the back goes through queue
// pop, square, sum, 8 root steps at two bits each and output load; a clamped
// one skips the root and a border zero skips square, sum and root, so the
// root loop sets the sustained rate on image interiors. Reset clears position,
// window and sizes (1024 x 1024); line stores are not cleared. A stalled
// result waits in the output register; behind it the back holds one finished
// beat and the queue two work items, after which the front raises full.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [sobm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sobm_pkg::CfgW-1:0]    cfg_data_i,
  // pixel input
  input  logic                         push,
  output logic                         full,
  input  logic [sobm_pkg::PixW-1:0]    pixel_i,
  // result output
  output logic                         empty,
  input  logic                         pop,
  output logic [sobm_pkg::MagW-1:0]    magnitude_o,
  output logic [sobm_pkg::PosW-1:0]    out_row_o,
  output logic [sobm_pkg::PosW-1:0]    out_col_o,
  output logic                         saturated_o,
  output logic                         frame_end_o
);

  logic            q_push, q_full, q_pop, q_empty;
  sobm_pkg::item_t q_wr_item, q_rd_item;

  // window, line stores and gradients
  sobm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .pixel_i    (pixel_i),
    .q_push_o   (q_push),
    .q_item_o   (q_wr_item),
    .q_full_i   (q_full)
  );

  // decoupling queue
  sobm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_wr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_rd_item),
    .empty_o (q_empty)
  );

  // magnitude and output register
  sobm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_item_i    (q_rd_item),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .empty       (empty),
    .pop         (pop),
    .magnitude_o (magnitude_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .saturated_o (saturated_o),
    .frame_end_o (frame_end_o)
  );

endmodule

// ===== sv/sobm_ram.sv =====
// ----------------------------------------------------------------------------
// sobm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sobm_front.sv =====
// ----------------------------------------------------------------------------
// sobm_front
// Input side: raster position, line stores, 3x3 window and gradient sums.
// Classifies each pixel as no result, border zero or interior work item.
// ----------------------------------------------------------------------------
module sobm_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [sobm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sobm_pkg::CfgW-1:0]   cfg_data_i,
  // pixel input
  input  logic                        push,
  output logic                        full,
  input  logic [sobm_pkg::PixW-1:0]   pixel_i,
  // to the work queue
  output logic                        q_push_o,
  output sobm_pkg::item_t             q_item_o,
  input  logic                        q_full_i
);

  localparam logic FrIdle = 1'b0;
  localparam logic FrLook = 1'b1;

  localparam int PixW  = sobm_pkg::PixW;
  localparam int SizeW = sobm_pkg::SizeW;
  localparam int ColW  = sobm_pkg::ColW;

  function automatic logic [SizeW-1:0] clamp_size(input logic [sobm_pkg::CfgW-1:0] v);
    logic [SizeW-1:0] r;
    begin
      if (32'(v) < sobm_pkg::MinSize) begin
        r = SizeW'(sobm_pkg::MinSize);
      end else if (32'(v) > sobm_pkg::MaxSize) begin
        r = SizeW'(sobm_pkg::MaxSize);
      end else begin
        r = SizeW'(v);
      end
      return r;
    end
  endfunction

  logic                state_q, state_d;
  logic [SizeW-1:0]    width_q, height_q;
  logic [ColW-1:0]     col_q, col_d, row_q, row_d;
  logic [PixW-1:0]     pix_q;
  logic [PixW-1:0]     win_q [6];
  logic [2*PixW-1:0]   line_rd;
  logic [PixW-1:0]     up_px, mid_px;
  logic                accept;
  logic                last_col, last_row;
  logic [PixW+1:0]     sx_pos, sx_neg, sy_pos, sy_neg;

  assign accept = push && !full;
  assign full   = (state_q == FrLook) || q_full_i;

  // line stores: one entry per column holds {row r-2, row r-1}
  sobm_ram #(
    .WIDTH (2 * PixW),
    .DEPTH (sobm_pkg::MaxSize)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (state_q == FrLook),
    .waddr_i (col_q),
    .wdata_i ({mid_px, pix_q}),
    .raddr_i (col_q),
    .rdata_o (line_rd)
  );

  assign up_px  = line_rd[2*PixW-1:PixW];
  assign mid_px = line_rd[PixW-1:0];

  // gradient sums; right column is {up, mid, pix}
  assign sx_pos = {2'b0, up_px} + {1'b0, mid_px, 1'b0} + {2'b0, pix_q};
  assign sx_neg = {2'b0, win_q[0]} + {1'b0, win_q[2], 1'b0} + {2'b0, win_q[4]};
  assign sy_pos = {2'b0, win_q[0]} + {1'b0, win_q[1], 1'b0} + {2'b0, up_px};
  assign sy_neg = {2'b0, win_q[4]} + {1'b0, win_q[5], 1'b0} + {2'b0, pix_q};

  assign last_col = SizeW'(col_q) == width_q - SizeW'(1);
  assign last_row = SizeW'(row_q) == height_q - SizeW'(1);

  // work item for the window centered at (row-1, col-1)
  always_comb begin
    q_item_o.gx        = $signed({1'b0, sx_pos}) - $signed({1'b0, sx_neg});
    q_item_o.gy        = $signed({1'b0, sy_pos}) - $signed({1'b0, sy_neg});
    q_item_o.orow      = sobm_pkg::PosW'(row_q - ColW'(1));
    q_item_o.ocol      = sobm_pkg::PosW'(col_q - ColW'(1));
    q_item_o.border    = (row_q == ColW'(1)) || (col_q == ColW'(1));
    q_item_o.frame_end = last_row && last_col;
  end

  assign q_push_o = (state_q == FrLook) && (row_q != '0) && (col_q != '0);

  // raster position advance
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (state_q == FrLook) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ColW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end else if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end
  end

  // sequencer: accept, then look up the line stores
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FrIdle:  if (accept) state_d = FrLook;
      FrLook:  state_d = FrIdle;
      default: state_d = FrIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FrIdle;
      width_q  <= SizeW'(sobm_pkg::MaxSize);
      height_q <= SizeW'(sobm_pkg::MaxSize);
      col_q    <= '0;
      row_q    <= '0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sobm_pkg::RegImageWidth:  width_q  <= clamp_size(cfg_data_i);
          sobm_pkg::RegImageHeight: height_q <= clamp_size(cfg_data_i);
          default: ;
        endcase
      end
      // shift the window one column left
      if (state_q == FrLook) begin
        win_q[0] <= win_q[1];
        win_q[1] <= up_px;
        win_q[2] <= win_q[3];
        win_q[3] <= mid_px;
        win_q[4] <= win_q[5];
        win_q[5] <= pix_q;
      end
    end
  end

  // incoming pixel
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= pixel_i;
    end
  end

  // an accepted beat always moves to the lookup cycle
  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == FrLook)
    else $error("front: accepted beat not followed by lookup");

  // items are only produced past the first row and column, never into a full queue
  a_push_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> (row_q != '0) && (col_q != '0) && !q_full_i)
    else $error("front: push at first row/column or into a full queue");

endmodule

// ===== sv/sobm_queue.sv =====
// ----------------------------------------------------------------------------
// sobm_queue
// Short flop-based queue of work items between front and back.
// ----------------------------------------------------------------------------
module sobm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sobm_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output sobm_pkg::item_t item_o,
  output logic            empty_o
);

  localparam int QPtrW = sobm_pkg::QPtrW;
  localparam int QCntW = sobm_pkg::QCntW;

  sobm_pkg::item_t     mem_q [sobm_pkg::QDepth];
  logic [QPtrW-1:0]    wptr_q, rptr_q;
  logic [QCntW-1:0]    cnt_q;
  logic                do_push, do_pop;

  assign full_o  = cnt_q == QCntW'(sobm_pkg::QDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rptr_q];

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    return (32'(p) == sobm_pkg::QDepth - 1) ? '0 : p + QPtrW'(1);
  endfunction

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= ptr_inc(wptr_q);
      if (do_pop)  rptr_q <= ptr_inc(rptr_q);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  // fill count tracks the pointers
  a_cnt_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || 32'(cnt_q) == sobm_pkg::QDepth) |-> wptr_q == rptr_q)
    else $error("queue: count and pointers disagree");

endmodule

// ===== sv/sobm_back.sv =====
// ----------------------------------------------------------------------------
// sobm_back
// Result side: squares the gradients, takes a bit-pair integer square root,
// saturates, and holds the result in an output register.
// ----------------------------------------------------------------------------
module sobm_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // from the work queue
  input  sobm_pkg::item_t            q_item_i,
  input  logic                       q_empty_i,
  output logic                       q_pop_o,
  // result output
  output logic                       empty,
  input  logic                       pop,
  output logic [sobm_pkg::MagW-1:0]  magnitude_o,
  output logic [sobm_pkg::PosW-1:0]  out_row_o,
  output logic [sobm_pkg::PosW-1:0]  out_col_o,
  output logic                       saturated_o,
  output logic                       frame_end_o
);

  localparam logic [2:0] BkIdle   = 3'd0;
  localparam logic [2:0] BkSquare = 3'd1;
  localparam logic [2:0] BkSum    = 3'd2;
  localparam logic [2:0] BkRoot   = 3'd3;
  localparam logic [2:0] BkDone   = 3'd4;

  localparam int GradW   = sobm_pkg::GradW;
  localparam int SqW     = sobm_pkg::SqW;
  localparam int SumW    = sobm_pkg::SumW;
  localparam int RootInW = sobm_pkg::RootInW;
  localparam int MagW    = sobm_pkg::MagW;
  localparam int PosW    = sobm_pkg::PosW;

  logic [2:0]                state_q;
  logic signed [GradW-1:0]   gx_q, gy_q;
  logic [PosW-1:0]           orow_q, ocol_q;
  logic                      fe_q, sat_q;
  logic [MagW-1:0]           mag_q;
  logic [SqW-1:0]            sqx_q, sqy_q;
  logic [RootInW-1:0]        rem_q, res_q, bit_q;
  logic signed [2*GradW-1:0] prod_x, prod_y;
  logic [SumW-1:0]           sum;
  logic [RootInW:0]          trial;
  logic                      take;
  logic [RootInW-1:0]        res_next, rem_next;

  logic                      out_valid_q, out_sat_q, out_fe_q;
  logic [MagW-1:0]           out_mag_q;
  logic [PosW-1:0]           out_row_q, out_col_q;
  logic                      load_out;

  assign q_pop_o  = (state_q == BkIdle) && !q_empty_i;
  assign load_out = (state_q == BkDone) && (!out_valid_q || pop);

  // squares and their sum
  assign prod_x = gx_q * gx_q;
  assign prod_y = gy_q * gy_q;
  assign sum    = {1'b0, sqx_q} + {1'b0, sqy_q};

  // one root step: two radicand bits per cycle
  assign trial = {1'b0, res_q} + {1'b0, bit_q};
  assign take  = {1'b0, rem_q} >= trial;
  always_comb begin
    if (take) begin
      rem_next = rem_q - trial[RootInW-1:0];
      res_next = (res_q >> 1) + bit_q;
    end else begin
      rem_next = rem_q;
      res_next = res_q >> 1;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
    end else begin
      unique case (state_q)
        BkIdle: begin
          if (q_pop_o) state_q <= q_item_i.border ? BkDone : BkSquare;
        end
        BkSquare: state_q <= BkSum;
        BkSum: begin
          state_q <= (sum[SumW-1:RootInW] != '0) ? BkDone : BkRoot;
        end
        BkRoot: begin
          if (bit_q == RootInW'(1)) state_q <= BkDone;
        end
        BkDone: begin
          if (load_out) state_q <= BkIdle;
        end
        default: state_q <= BkIdle;
      endcase
    end
  end

  // work registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BkIdle: begin
        if (q_pop_o) begin
          gx_q   <= q_item_i.gx;
          gy_q   <= q_item_i.gy;
          orow_q <= q_item_i.orow;
          ocol_q <= q_item_i.ocol;
          fe_q   <= q_item_i.frame_end;
          mag_q  <= '0;
          sat_q  <= 1'b0;
        end
      end
      BkSquare: begin
        sqx_q <= prod_x[SqW-1:0];
        sqy_q <= prod_y[SqW-1:0];
      end
      BkSum: begin
        if (sum[SumW-1:RootInW] != '0) begin
          mag_q <= '1;
          sat_q <= 1'b1;
        end
        rem_q <= sum[RootInW-1:0];
        res_q <= '0;
        bit_q <= RootInW'(1) << (RootInW - 2);
      end
      BkRoot: begin
        rem_q <= rem_next;
        res_q <= res_next;
        bit_q <= bit_q >> 2;
        if (bit_q == RootInW'(1)) mag_q <= res_next[MagW-1:0];
      end
      BkDone: ;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_mag_q <= mag_q;
      out_row_q <= orow_q;
      out_col_q <= ocol_q;
      out_sat_q <= sat_q;
      out_fe_q  <= fe_q;
    end
  end

  assign empty       = !out_valid_q;
  assign magnitude_o = out_mag_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign saturated_o = out_sat_q;
  assign frame_end_o = out_fe_q;

  // a clamped result always reads full scale
  a_sat_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_sat_q) |-> out_mag_q == '1)
    else $error("back: saturated result below full scale");

  // the root never needs more than eight result bits
  a_root_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkRoot && bit_q == RootInW'(1)) |-> res_next[RootInW-1:MagW] == '0)
    else $error("back: root overflowed the magnitude width");

  // a result is never overwritten while still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop) |=> out_valid_q && $stable(out_mag_q) && $stable(out_col_q))
    else $error("back: waiting result lost");

endmodule

// ===== tb/sv/sobel_edge_magnitude_test.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_test
// Self-checking bench for the streaming Sobel edge magnitude block. A short
// table of hand-computed frames runs first, then random frames of many sizes
// with random sender gaps and receiver stalls. All but table beats are checked
// against an in-bench model of the line stores, window and integer root.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_test;
  import sobm_pkg::*;

  localparam int CycleLimit   = 1_000_000;
  localparam int RandomItems  = 1850;
  localparam int SettleCycles = 60;    // front + two queued interior roots + output
  localparam int LongHold     = 300;
  localparam int DirectedRows = 19;
  localparam int MaxReports   = 10;

  typedef struct packed {
    logic [MagW-1:0] mag;
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
    logic            sat;
    logic            last;
  } edge_result_t;

  typedef enum logic [1:0] {ROW_SIZES, ROW_PIXEL, ROW_KNOWN} row_kind_e;

  typedef struct packed {
    row_kind_e       kind;
    logic [CfgW-1:0] width_val;
    logic [CfgW-1:0] height_val;
    logic [PixW-1:0] pix;
    edge_result_t    want;
  } plan_row_t;

  localparam edge_result_t NoEdge = '0;

  // DUT-facing signals
  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i  = RegImageWidth;
  logic [CfgW-1:0]    cfg_data_i = '0;
  logic               push       = 1'b0;
  logic               full;
  logic [PixW-1:0]    pixel_i    = '0;
  logic               empty;
  logic               pop        = 1'b0;
  logic [MagW-1:0]    magnitude_o;
  logic [PosW-1:0]    out_row_o;
  logic [PosW-1:0]    out_col_o;
  logic               saturated_o;
  logic               frame_end_o;

  // hand-computed expectation riding along with the offered pixel
  logic               known_edge = 1'b0;
  edge_result_t       known_want = '0;

  // model state: line stores, two older window columns, position, sizes
  bit [PixW-1:0] upper_row  [MaxSize];
  bit [PixW-1:0] middle_row [MaxSize];
  bit [PixW-1:0] left_col   [3];
  bit [PixW-1:0] center_col [3];
  int            next_row   = 0;
  int            next_col   = 0;
  int            row_len    = MaxSize;
  int            frame_rows = MaxSize;

  edge_result_t  pending_edges [$];
  int            fault_count   = 0;
  int            cycle_count   = 0;
  int            send_idle_pct = 0;
  int            stall_pct     = 0;
  int            hold_requests = 0;
  int            holds_served  = 0;
  int            hold_left     = 0;

  sobel_edge_magnitude u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .pixel_i     (pixel_i),
    .empty       (empty),
    .pop         (pop),
    .magnitude_o (magnitude_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .saturated_o (saturated_o),
    .frame_end_o (frame_end_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run-away guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("sobel_edge_magnitude test failed");
      $finish;
    end
  end

  function automatic void note_fault(input string msg);
    fault_count++;
    if (fault_count <= MaxReports) $display("%s", msg);
  endfunction

  // size register value -> size in use
  function automatic int size_in_use(input logic [CfgW-1:0] v);
    if (v < MinSize) return MinSize;
    if (v > MaxSize) return MaxSize;
    return int'(v);
  endfunction

  // floor(sqrt(v)), bit by bit from the top; roots stay below 2**12
  function automatic int unsigned root_floor(input int unsigned v);
    int unsigned root;
    int unsigned trial;
    root = 0;
    for (int b = 11; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Advance the model by one pixel; returns 1 when an edge beat is due.
  function automatic bit predict_edge(input logic [PixW-1:0] pix,
                                      output edge_result_t res);
    int r;
    int c;
    int gx;
    int gy;
    int unsigned root;
    bit emits;
    r = next_row;
    c = next_col;
    res = NoEdge;
    if (r >= frame_rows || c >= row_len) begin
      r = 0;
      c = 0;
    end
    emits = (r >= 1 && c >= 1);
    if (emits) begin
      res.row  = PosW'(r - 1);
      res.col  = PosW'(c - 1);
      res.last = (r == frame_rows - 1 && c == row_len - 1);
      // border positions stay zero
      if (r >= 2 && c >= 2) begin
        gx = (int'(upper_row[c]) + 2 * int'(middle_row[c]) + int'(pix))
           - (int'(left_col[0]) + 2 * int'(left_col[1]) + int'(left_col[2]));
        gy = (int'(left_col[0]) + 2 * int'(center_col[0]) + int'(upper_row[c]))
           - (int'(left_col[2]) + 2 * int'(center_col[2]) + int'(pix));
        root = root_floor(gx * gx + gy * gy);
        res.sat = (root > 255);
        res.mag = res.sat ? MagW'(255) : MagW'(root);
      end
    end
    // slide the window one column and roll the line stores
    left_col      = center_col;
    center_col[0] = upper_row[c];
    center_col[1] = middle_row[c];
    center_col[2] = pix;
    upper_row[c]  = middle_row[c];
    middle_row[c] = pix;
    c++;
    if (c >= row_len) begin
      c = 0;
      r++;
      if (r >= frame_rows) r = 0;
    end
    next_row = r;
    next_col = c;
    return emits;
  endfunction

  // Input, config and result monitor plus the pop driver
  always @(posedge clk_i) begin
    edge_result_t predicted;
    edge_result_t got;
    edge_result_t want;
    bit emits;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegImageWidth) row_len = size_in_use(cfg_data_i);
        else frame_rows = size_in_use(cfg_data_i);
        next_row = 0;
        next_col = 0;
      end
      if (push && !full) begin
        emits = predict_edge(pixel_i, predicted);
        if (known_edge) pending_edges.push_back(known_want);
        else if (emits) pending_edges.push_back(predicted);
      end
      if (pop && !empty) begin
        got = '{magnitude_o, out_row_o, out_col_o, saturated_o, frame_end_o};
        if (pending_edges.size() == 0) begin
          note_fault($sformatf("edge beat with none expected: mag %0d at (%0d,%0d)",
                               got.mag, got.row, got.col));
        end else begin
          want = pending_edges.pop_front();
          if (got !== want)
            note_fault($sformatf({"edge mismatch: expected mag %0d sat %0b end %0b",
                                  " at (%0d,%0d), got mag %0d sat %0b end %0b at (%0d,%0d)"},
                                 want.mag, want.sat, want.last, want.row, want.col,
                                 got.mag, got.sat, got.last, got.row, got.col));
        end
      end
    end
    // long hold-off on request, otherwise random stalls
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pop <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served = holds_served + 1;
      hold_left = LongHold;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Hand-computed 3x3 frames: a saturating step edge, then a weak one.
  function automatic plan_row_t directed_row(input int i);
    case (i)
      // sizes below the minimum clamp to 3 x 3
      0:  return '{ROW_SIZES, 11'd0, 11'd2, 8'd0, NoEdge};
      // frame A: 0 255 255 / 0 128 255 / 0 0 255
      1:  return '{ROW_PIXEL, '0, '0, 8'd0,   NoEdge};
      2:  return '{ROW_PIXEL, '0, '0, 8'd255, NoEdge};
      3:  return '{ROW_PIXEL, '0, '0, 8'd255, NoEdge};
      4:  return '{ROW_PIXEL, '0, '0, 8'd0,   NoEdge};
      5:  return '{ROW_KNOWN, '0, '0, 8'd128, '{8'd0, 10'd0, 10'd0, 1'b0, 1'b0}};
      6:  return '{ROW_KNOWN, '0, '0, 8'd255, '{8'd0, 10'd0, 10'd1, 1'b0, 1'b0}};
      7:  return '{ROW_PIXEL, '0, '0, 8'd0,   NoEdge};
      8:  return '{ROW_KNOWN, '0, '0, 8'd0,   '{8'd0, 10'd1, 10'd0, 1'b0, 1'b0}};
      9:  return '{ROW_KNOWN, '0, '0, 8'd255, '{8'd255, 10'd1, 10'd1, 1'b1, 1'b1}};
      // frame B after wrap: right column 1, rest 0 -> gx 4, gy 0
      10: return '{ROW_PIXEL, '0, '0, 8'd0, NoEdge};
      11: return '{ROW_PIXEL, '0, '0, 8'd0, NoEdge};
      12: return '{ROW_PIXEL, '0, '0, 8'd1, NoEdge};
      13: return '{ROW_PIXEL, '0, '0, 8'd0, NoEdge};
      14: return '{ROW_KNOWN, '0, '0, 8'd0, '{8'd0, 10'd0, 10'd0, 1'b0, 1'b0}};
      15: return '{ROW_KNOWN, '0, '0, 8'd1, '{8'd0, 10'd0, 10'd1, 1'b0, 1'b0}};
      16: return '{ROW_PIXEL, '0, '0, 8'd0, NoEdge};
      17: return '{ROW_KNOWN, '0, '0, 8'd0, '{8'd0, 10'd1, 10'd0, 1'b0, 1'b0}};
      default: return '{ROW_KNOWN, '0, '0, 8'd1, '{8'd4, 10'd1, 10'd1, 1'b0, 1'b1}};
    endcase
  endfunction

  // extremes show up often so saturation is common
  function automatic logic [PixW-1:0] random_pixel();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return PixW'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one pixel beat, holding it until the block takes it
  task automatic offer_pixel(input logic [PixW-1:0] pix, input logic known,
                             input edge_result_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push       <= 1'b1;
    pixel_i    <= pix;
    known_edge <= known;
    known_want <= want;
    do @(posedge clk_i); while (full);
  endtask

  // Wait for every expected beat, then let the pipeline go quiet
  task automatic settle_idle();
    push <= 1'b0;
    do @(negedge clk_i); while (pending_edges.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Both size registers, back to back
  task automatic write_sizes(input logic [CfgW-1:0] wv, input logic [CfgW-1:0] hv);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegImageWidth;
    cfg_data_i <= wv;
    @(posedge clk_i);
    cfg_idx_i  <= RegImageHeight;
    cfg_data_i <= hv;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Stimulus
  initial begin
    plan_row_t row;
    int phase;
    int sent;
    int w_val;
    int h_val;
    int count;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    for (int i = 0; i < DirectedRows; i++) begin
      row = directed_row(i);
      if (row.kind == ROW_SIZES) begin
        settle_idle();
        write_sizes(row.width_val, row.height_val);
      end else begin
        offer_pixel(row.pix, row.kind == ROW_KNOWN, row.want);
      end
    end

    // random frames; one full-width and one full-height setting on the way
    phase = 0;
    sent  = 0;
    while (sent < RandomItems || phase <= 5) begin
      settle_idle();
      if (phase == 2) begin
        w_val = $urandom_range(MaxSize, 2047);
        h_val = $urandom_range(0, 6);
        count = MaxSize + $urandom_range(4, 16);
      end else if (phase == 5) begin
        w_val = $urandom_range(0, 3);
        h_val = $urandom_range(MaxSize, 2047);
        count = $urandom_range(120, 200);
      end else begin
        w_val = $urandom_range(0, 12);
        h_val = $urandom_range(0, 8);
        count = $urandom_range(60, 180);
      end
      write_sizes(CfgW'(w_val), CfgW'(h_val));
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 88; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 88; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      // receiver backs off while pixels keep coming, so the input stalls
      if (phase == 0) hold_requests = hold_requests + 1;
      repeat (count) offer_pixel(random_pixel(), 1'b0, NoEdge);
      sent  = sent + count;
      phase = phase + 1;
    end

    settle_idle();
    if (fault_count == 0) $display("sobel_edge_magnitude test passed");
    else $display("sobel_edge_magnitude test failed");
    $finish;
  end

endmodule
